FILE: hw/rtl/sspc_pkg.sv
// sspc_pkg: shared types, widths, opcodes and register indexes for the
// stepper speed pulse controller. No dependencies.
`timescale 1ns / 1ps

package sspc_pkg;

	localparam int BASE_W  = 16;  // half period and base width
	localparam int SPEED_W = 10;  // speed setting width
	localparam int OP_W    = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam int SPEED_DIVISOR_DEF = 10;

	// opcodes
	localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
	localparam logic [OP_W-1:0] OP_INC       = 3'd1;
	localparam logic [OP_W-1:0] OP_DEC       = 3'd2;
	localparam logic [OP_W-1:0] OP_TOGGLE    = 3'd3;
	localparam logic [OP_W-1:0] OP_BOOST_ON  = 3'd4;
	localparam logic [OP_W-1:0] OP_BOOST_OFF = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_NORM  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOOST = 4'd3;

	// reset values
	localparam logic [BASE_W-1:0]  RST_BASE      = 16'd3700;
	localparam logic [SPEED_W-1:0] RST_MIN_SPEED = 10'd1;
	localparam logic [SPEED_W-1:0] RST_MAX_NORM  = 10'd500;
	localparam logic [SPEED_W-1:0] RST_MAX_BOOST = 10'd500;
	localparam logic [SPEED_W-1:0] RST_NORM_SPD  = 10'd10;
	localparam logic [SPEED_W-1:0] RST_BOOST_SPD = 10'd200;
	localparam logic [BASE_W-1:0]  RST_NORM_HP   = 16'd3700;
	localparam logic [BASE_W-1:0]  RST_BOOST_HP  = 16'd185;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_RESULT
	} sspc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic exec;      // apply the captured op
		logic out_load;  // load the result register
	} sspc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_start; // speed changed, half period recompute launched
		logic div_done;  // new half period written
	} sspc_stat_t;

endpackage

FILE: hw/rtl/sspc_ifs.sv
// sspc_ifs: valid/ready channel interfaces for the input, result and
// configuration beats. Depends on sspc_pkg.
`timescale 1ns / 1ps

interface sspc_in_if;
	logic                        valid;
	logic                        ready;
	logic [sspc_pkg::OP_W-1:0]   opcode;
	logic                        left_switch;
	logic                        right_switch;

	modport source (output valid, opcode, left_switch, right_switch, input ready);
	modport sink   (input valid, opcode, left_switch, right_switch, output ready);
endinterface

interface sspc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         step_level;
	logic                         dir_level;
	logic                         driver_off;
	logic [sspc_pkg::SPEED_W-1:0] normal_speed_out;
	logic [sspc_pkg::SPEED_W-1:0] boost_speed_out;
	logic                         selected_out;
	logic                         boost_out;

	modport source (output valid, step_level, dir_level, driver_off, normal_speed_out,
		boost_speed_out, selected_out, boost_out, input ready);
	modport sink   (input valid, step_level, dir_level, driver_off, normal_speed_out,
		boost_speed_out, selected_out, boost_out, output ready);
endinterface

interface sspc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sspc_pkg::CFG_IDX_W-1:0]  index;
	logic [sspc_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: hw/rtl/stepper_speed_pulse_controller.sv
// stepper_speed_pulse_controller: top level, joins controller and datapath.
// Depends on sspc_pkg, sspc_ifs, sspc_ctrl, sspc_dp (with sspc_div).
`timescale 1ns / 1ps
//
// Usage
//  - in_ch carries one command beat: tick (1 us), increase, decrease,
//    toggle selected setting, boost on/off, plus the two direction
//    switches, which only count on a tick.
//  - out_ch returns exactly one result beat per command: step, direction
//    and enable levels, both speed settings, selection and boost flag,
//    all as they stand after the command.
//  - cfg_ch writes the base, min speed and the two max speeds by index;
//    always ready. The user writes only while no command is in flight;
//    the block itself does not enforce this.
//  - An accepted beat is captured, executed and loaded into the result
//    register; when a speed changes, the bit-serial divider (16 quotient
//    bits, one per cycle) first recomputes the half period. One command
//    at a time; in_ch.ready is high only while the sequencer is idle.
//  - The result register decouples the channels: a new command is taken
//    while the previous result still waits; that command then holds in
//    its result state until out_ch takes the pending beat.
//  - Reset (arst_n low) returns every setting to its default: driver off,
//    step low, normal speed 10, boost speed 200, no result pending.
//

module stepper_speed_pulse_controller #(
	parameter int SPEED_DIVISOR = sspc_pkg::SPEED_DIVISOR_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sspc_in_if.sink    in_ch,
	sspc_out_if.source out_ch,
	sspc_cfg_if.sink   cfg_ch
);

	sspc_pkg::sspc_cmd_t  cmd;
	sspc_pkg::sspc_stat_t stat;
	logic                 cfg_we;

	// user changes config only when idle (unenforced); the port never stalls
	assign cfg_ch.ready = 1'b1;
	assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

	// sequencer: idle -> exec -> (divide) -> result
	sspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// state, step timing, half-period recompute, result register
	sspc_dp #(
		.SPEED_DIVISOR (SPEED_DIVISOR)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_ch.index),
		.cfg_wdata        (cfg_ch.wdata),
		.opcode           (in_ch.opcode),
		.left_switch      (in_ch.left_switch),
		.right_switch     (in_ch.right_switch),
		.step_level       (out_ch.step_level),
		.dir_level        (out_ch.dir_level),
		.driver_off       (out_ch.driver_off),
		.normal_speed_out (out_ch.normal_speed_out),
		.boost_speed_out  (out_ch.boost_speed_out),
		.selected_out     (out_ch.selected_out),
		.boost_out        (out_ch.boost_out)
	);

`ifndef ASSERT_OFF
	// an accepted beat is executed in the very next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> cmd.exec)
		else $error("accepted beat not executed");

	// no new beat is taken while a result is being produced
	a_no_accept_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ch.ready)
		else $error("input ready during result load");

	// a divide is launched only while executing a command
	a_div_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_start |-> cmd.exec)
		else $error("divide started outside exec");

	// a loaded result shows up as valid on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_ch.valid)
		else $error("loaded result not valid");
`endif

endmodule

FILE: hw/rtl/sspc_div.sv
// sspc_div: restoring divider, one quotient bit per cycle.
// Depends on sspc_pkg for operand widths.
`timescale 1ns / 1ps

module sspc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sspc_pkg::BASE_W-1:0]   dividend,
	input  logic [sspc_pkg::SPEED_W-1:0]  divisor,
	output logic                          done,
	output logic [sspc_pkg::BASE_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(sspc_pkg::BASE_W + 1);

	logic [CNT_W-1:0]              count_q;
	logic                          busy_q;
	logic                          done_q;
	logic [sspc_pkg::SPEED_W-1:0]  rem_q;
	logic [sspc_pkg::SPEED_W-1:0]  dvs_q;
	logic [sspc_pkg::BASE_W-1:0]   quo_q;
	logic [sspc_pkg::SPEED_W:0]    trial;
	logic [sspc_pkg::SPEED_W:0]    diff;
	logic                          fits;

	assign trial = {rem_q, quo_q[sspc_pkg::BASE_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(sspc_pkg::BASE_W);
			end else if (busy_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[sspc_pkg::SPEED_W-1:0];
				quo_q <= {quo_q[sspc_pkg::BASE_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[sspc_pkg::SPEED_W-1:0];
				quo_q <= {quo_q[sspc_pkg::BASE_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/sspc_ctrl.sv
// sspc_ctrl: sequencing state machine and result-valid flag.
// Depends on sspc_pkg (state enum, command and status structs).
`timescale 1ns / 1ps

module sspc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  sspc_pkg::sspc_stat_t  stat,
	output sspc_pkg::sspc_cmd_t   cmd
);

	sspc_pkg::sspc_state_t state_q, state_d;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sspc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sspc_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = sspc_pkg::ST_EXEC;
			end
			sspc_pkg::ST_EXEC: begin
				state_d = stat.div_start ? sspc_pkg::ST_DIV : sspc_pkg::ST_RESULT;
			end
			sspc_pkg::ST_DIV: begin
				if (stat.div_done)
					state_d = sspc_pkg::ST_RESULT;
			end
			sspc_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready)
					state_d = sspc_pkg::ST_IDLE;
			end
			default: state_d = sspc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			sspc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sspc_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			sspc_pkg::ST_RESULT: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/sspc_dp.sv
// sspc_dp: config registers, speed/half-period state, step timing and
// result register. Depends on sspc_pkg and sspc_div.
`timescale 1ns / 1ps

module sspc_dp #(
	parameter int SPEED_DIVISOR = sspc_pkg::SPEED_DIVISOR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sspc_pkg::sspc_cmd_t               cmd,
	output sspc_pkg::sspc_stat_t              stat,
	input  logic                              cfg_we,
	input  logic [sspc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sspc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [sspc_pkg::OP_W-1:0]         opcode,
	input  logic                              left_switch,
	input  logic                              right_switch,
	output logic                              step_level,
	output logic                              dir_level,
	output logic                              driver_off,
	output logic [sspc_pkg::SPEED_W-1:0]      normal_speed_out,
	output logic [sspc_pkg::SPEED_W-1:0]      boost_speed_out,
	output logic                              selected_out,
	output logic                              boost_out
);

	localparam int BW = sspc_pkg::BASE_W;
	localparam int SW = sspc_pkg::SPEED_W;

	// reciprocal of the speed divisor; exact for any SW-bit speed and divisors up to 128
	localparam int RCP_SH = SW + 7;
	localparam int RCP_W  = RCP_SH + 1;
	localparam logic [RCP_W-1:0] RCP_M =
		RCP_W'((2**RCP_SH + SPEED_DIVISOR - 1) / SPEED_DIVISOR);

	// config
	logic [BW-1:0] base_q;
	logic [SW-1:0] min_speed_q, max_norm_q, max_boost_q;

	// state
	logic [SW-1:0] norm_spd_q, boost_spd_q;
	logic [BW-1:0] norm_hp_q, boost_hp_q;
	logic          sel_q, boost_q, dir_q, drv_off_q, step_q;
	logic [BW-1:0] tick_cnt_q;

	// captured beat
	logic [sspc_pkg::OP_W-1:0] op_q;
	logic                      left_q, right_q;

	// result register
	logic          step_out_q, dir_out_q, drv_out_q, sel_out_q, boost_out_q;
	logic [SW-1:0] norm_out_q, boost_spd_out_q;

	// speed update
	logic [SW-1:0] cur_spd, max_spd, new_spd, dec_q10, divisor;
	logic          is_inc, is_dec, spd_chg;
	logic [SW+RCP_W-1:0] dec_prod;

	// tick
	logic [BW-1:0] hp, hp_eff;
	logic [BW:0]   cnt_inc;
	logic          wrap, running;

	logic          div_done;
	logic [BW-1:0] quotient;

	assign cur_spd = sel_q ? boost_spd_q : norm_spd_q;
	assign max_spd = sel_q ? max_boost_q : max_norm_q;
	assign is_inc  = (op_q == sspc_pkg::OP_INC) && (cur_spd < max_spd);
	assign is_dec  = (op_q == sspc_pkg::OP_DEC) && (cur_spd > min_speed_q);
	assign spd_chg = cmd.exec && (is_inc || is_dec);
	assign new_spd = is_inc ? cur_spd + SW'(1) : cur_spd - SW'(1);

	// speed decade; zero decade divides by one
	assign dec_prod = {{RCP_W{1'b0}}, new_spd} * {{SW{1'b0}}, RCP_M};
	assign dec_q10  = dec_prod[RCP_SH +: SW];
	assign divisor  = (dec_q10 == '0) ? SW'(1) : dec_q10;

	assign hp      = boost_q ? boost_hp_q : norm_hp_q;
	assign hp_eff  = (hp == '0) ? BW'(1) : hp;
	assign cnt_inc = {1'b0, tick_cnt_q} + (BW+1)'(1);
	assign wrap    = cnt_inc >= {1'b0, hp_eff};
	assign running = left_q ^ right_q;

	sspc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (spd_chg),
		.dividend (base_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	assign stat.div_start = spd_chg;
	assign stat.div_done  = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= sspc_pkg::RST_BASE;
			min_speed_q <= sspc_pkg::RST_MIN_SPEED;
			max_norm_q  <= sspc_pkg::RST_MAX_NORM;
			max_boost_q <= sspc_pkg::RST_MAX_BOOST;
		end else if (cfg_we) begin
			case (cfg_index)
				sspc_pkg::CFG_BASE:      base_q      <= cfg_wdata[BW-1:0];
				sspc_pkg::CFG_MIN_SPEED: min_speed_q <= cfg_wdata[SW-1:0];
				sspc_pkg::CFG_MAX_NORM:  max_norm_q  <= cfg_wdata[SW-1:0];
				sspc_pkg::CFG_MAX_BOOST: max_boost_q <= cfg_wdata[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_spd_q  <= sspc_pkg::RST_NORM_SPD;
			boost_spd_q <= sspc_pkg::RST_BOOST_SPD;
			norm_hp_q   <= sspc_pkg::RST_NORM_HP;
			boost_hp_q  <= sspc_pkg::RST_BOOST_HP;
			sel_q       <= 1'b0;
			boost_q     <= 1'b0;
			dir_q       <= 1'b0;
			drv_off_q   <= 1'b1;
			step_q      <= 1'b0;
			tick_cnt_q  <= '0;
		end else begin
			if (cmd.exec) begin
				case (op_q)
					sspc_pkg::OP_TICK: begin
						if (!running) begin
							drv_off_q  <= 1'b1;
							step_q     <= 1'b0;
							tick_cnt_q <= '0;
						end else begin
							drv_off_q <= 1'b0;
							dir_q     <= !left_q;
							if (wrap) begin
								step_q     <= !step_q;
								tick_cnt_q <= '0;
							end else begin
								tick_cnt_q <= cnt_inc[BW-1:0];
							end
						end
					end
					sspc_pkg::OP_INC, sspc_pkg::OP_DEC: begin
						if (spd_chg) begin
							if (sel_q)
								boost_spd_q <= new_spd;
							else
								norm_spd_q <= new_spd;
						end
					end
					sspc_pkg::OP_TOGGLE:    sel_q   <= !sel_q;
					sspc_pkg::OP_BOOST_ON:  boost_q <= 1'b1;
					sspc_pkg::OP_BOOST_OFF: boost_q <= 1'b0;
					default: begin
					end
				endcase
			end
			// selection cannot move while the divider runs
			if (div_done) begin
				if (sel_q)
					boost_hp_q <= quotient;
				else
					norm_hp_q <= quotient;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			left_q  <= left_switch;
			right_q <= right_switch;
		end
		if (cmd.out_load) begin
			step_out_q      <= step_q;
			dir_out_q       <= dir_q;
			drv_out_q       <= drv_off_q;
			norm_out_q      <= norm_spd_q;
			boost_spd_out_q <= boost_spd_q;
			sel_out_q       <= sel_q;
			boost_out_q     <= boost_q;
		end
	end

	assign step_level       = step_out_q;
	assign dir_level        = dir_out_q;
	assign driver_off       = drv_out_q;
	assign normal_speed_out = norm_out_q;
	assign boost_speed_out  = boost_spd_out_q;
	assign selected_out     = sel_out_q;
	assign boost_out        = boost_out_q;

endmodule

FILE: test/stepper_speed_pulse_controller_tb.sv
// stepper_speed_pulse_controller_tb: self-checking bench for the stepper speed pulse
// controller. Drives commands and register writes, predicts each result beat.
// Depends on sspc_pkg, sspc_ifs and the controller RTL.
`timescale 1ns / 1ps

module stepper_speed_pulse_controller_tb;

	localparam int OW = sspc_pkg::OP_W;
	localparam int IW = sspc_pkg::CFG_IDX_W;
	localparam int DW = sspc_pkg::CFG_DATA_W;
	localparam int BW = sspc_pkg::BASE_W;
	localparam int SW = sspc_pkg::SPEED_W;

	// unused opcodes: block must report state and change nothing
	localparam logic [OW-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OW-1:0] OP_SPARE7 = 3'd7;
	// out-of-range register indexes, writes are dropped
	localparam logic [IW-1:0] CFG_NONE_LO = 4'd4;
	localparam logic [IW-1:0] CFG_NONE_HI = 4'd15;

	localparam int IDLE_PCT       = 34;   // chance of a bubble per cycle on either side
	localparam int HOLD_CYCLES    = 300;  // one long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000; // cycles with no beat on any channel
	localparam int DRAIN_CYCLES   = 30;   // > worst-case latency of a speed change
	localparam int MAX_REPORTS    = 100;

	typedef struct packed {
		logic [OW-1:0] opcode;
		logic          left_switch;
		logic          right_switch;
	} motor_cmd_t;

	typedef struct packed {
		logic          step_level;
		logic          dir_level;
		logic          driver_off;
		logic [SW-1:0] normal_speed;
		logic [SW-1:0] boost_speed;
		logic          selected;
		logic          boost;
	} motor_status_t;

	logic clk = 1'b0;
	logic arst_n;

	sspc_in_if  in_ch();
	sspc_out_if out_ch();
	sspc_cfg_if cfg_ch();

	stepper_speed_pulse_controller dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #4 clk = ~clk;

	motor_cmd_t    pending_cmds[$];    // commands not yet offered
	motor_status_t expected_status[$]; // predicted result beats, oldest first

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          sender_steady = 1'b0;   // no bubbles on the command side
	bit          receiver_steady = 1'b0; // no bubbles on the result side
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;

	// switch pair held across tick runs so the motor actually gets to step
	logic sw_left = 1'b1;
	logic sw_right = 1'b0;

	// register copies
	logic [BW-1:0] cfg_base;
	logic [SW-1:0] cfg_min;
	logic [SW-1:0] cfg_max_norm;
	logic [SW-1:0] cfg_max_boost;

	// motor state as the predictor sees it
	logic [SW-1:0] norm_spd;
	logic [SW-1:0] boost_spd;
	logic [BW-1:0] norm_hp;
	logic [BW-1:0] boost_hp;
	logic          sel_boost;
	logic          boost_on;
	logic          dir_right;
	logic          drv_off;
	logic          step_hi;
	logic [BW-1:0] tick_cnt;

	task automatic reset_motor_model();
		cfg_base      = sspc_pkg::RST_BASE;
		cfg_min       = sspc_pkg::RST_MIN_SPEED;
		cfg_max_norm  = sspc_pkg::RST_MAX_NORM;
		cfg_max_boost = sspc_pkg::RST_MAX_BOOST;
		norm_spd  = sspc_pkg::RST_NORM_SPD;
		boost_spd = sspc_pkg::RST_BOOST_SPD;
		norm_hp   = sspc_pkg::RST_NORM_HP;
		boost_hp  = sspc_pkg::RST_BOOST_HP;
		sel_boost = 1'b0;
		boost_on  = 1'b0;
		dir_right = 1'b0;
		drv_off   = 1'b1;
		step_hi   = 1'b0;
		tick_cnt  = '0;
	endtask

	// base / (speed / divisor); a speed under one decade divides by 1
	function automatic logic [BW-1:0] half_period_for(logic [SW-1:0] spd);
		int unsigned decade;
		decade = spd / sspc_pkg::SPEED_DIVISOR_DEF;
		if (decade == 0)
			decade = 1;
		return BW'(cfg_base / decade);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// apply one command to the motor state, return the status beat it yields
	function automatic motor_status_t step_motor(motor_cmd_t c);
		motor_status_t s;
		logic [BW-1:0] hp;
		case (c.opcode)
			sspc_pkg::OP_TICK: begin
				if (c.left_switch == c.right_switch) begin
					// stopped: driver off, step low, count cleared, direction kept
					drv_off  = 1'b1;
					step_hi  = 1'b0;
					tick_cnt = '0;
				end else begin
					drv_off   = 1'b0;
					dir_right = c.right_switch;
					hp = boost_on ? boost_hp : norm_hp;
					if (hp == 0)
						hp = BW'(1);
					// counter may already be past a freshly shortened period
					if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, hp}) begin
						step_hi  = ~step_hi;
						tick_cnt = '0;
					end else begin
						tick_cnt = tick_cnt + 1'b1;
					end
				end
			end
			sspc_pkg::OP_INC: begin
				if (!sel_boost) begin
					if (norm_spd < cfg_max_norm) begin
						norm_spd = norm_spd + 1'b1;
						norm_hp  = half_period_for(norm_spd);
					end
				end else if (boost_spd < cfg_max_boost) begin
					boost_spd = boost_spd + 1'b1;
					boost_hp  = half_period_for(boost_spd);
				end
			end
			sspc_pkg::OP_DEC: begin
				if (!sel_boost) begin
					if (norm_spd > cfg_min) begin
						norm_spd = norm_spd - 1'b1;
						norm_hp  = half_period_for(norm_spd);
					end
				end else if (boost_spd > cfg_min) begin
					boost_spd = boost_spd - 1'b1;
					boost_hp  = half_period_for(boost_spd);
				end
			end
			sspc_pkg::OP_TOGGLE:    sel_boost = ~sel_boost;
			sspc_pkg::OP_BOOST_ON:  boost_on = 1'b1;
			sspc_pkg::OP_BOOST_OFF: boost_on = 1'b0;
			default: ;
		endcase
		s.step_level   = step_hi;
		s.dir_level    = dir_right;
		s.driver_off   = drv_off;
		s.normal_speed = norm_spd;
		s.boost_speed  = boost_spd;
		s.selected     = sel_boost;
		s.boost        = boost_on;
		return s;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Command driver: takes the next pending command whenever the bus is free or
	// the current beat goes through, unless a random bubble is drawn. Each
	// accepted beat is run through the predictor right at the accepting edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		motor_cmd_t nxt;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				expected_status.push_back(step_motor({in_ch.opcode, in_ch.left_switch,
					in_ch.right_switch}));
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_cmds.size() != 0 &&
					(sender_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_cmds.pop_front();
					in_ch.valid        <= 1'b1;
					in_ch.opcode       <= nxt.opcode;
					in_ch.left_switch  <= nxt.left_switch;
					in_ch.right_switch <= nxt.right_switch;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result monitor: compares every beat with the oldest prediction.
	// Ready drops at random, and once, on request, for a long hold-off that
	// this process counts itself; the command side keeps offering meanwhile
	// so the result register fills and in_ch stalls.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		motor_status_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_status.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat with no command pending", $time);
				end else begin
					want = expected_status.pop_front();
					check_field("step_level", 32'(want.step_level),
						32'(out_ch.step_level));
					check_field("dir_level", 32'(want.dir_level),
						32'(out_ch.dir_level));
					check_field("driver_off", 32'(want.driver_off),
						32'(out_ch.driver_off));
					check_field("normal_speed_out", 32'(want.normal_speed),
						32'(out_ch.normal_speed_out));
					check_field("boost_speed_out", 32'(want.boost_speed),
						32'(out_ch.boost_speed_out));
					check_field("selected_out", 32'(want.selected),
						32'(out_ch.selected_out));
					check_field("boost_out", 32'(want.boost),
						32'(out_ch.boost_out));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			out_ch.ready <= (hold_left == 0) &&
				(receiver_steady || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// watchdog: any beat on any channel counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("stepper_speed_pulse_controller: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// register write; only called with no command in flight
	task automatic cfg_write(logic [IW-1:0] idx, logic [DW-1:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			sspc_pkg::CFG_BASE:      cfg_base      = data[BW-1:0];
			sspc_pkg::CFG_MIN_SPEED: cfg_min       = data[SW-1:0];
			sspc_pkg::CFG_MAX_NORM:  cfg_max_norm  = data[SW-1:0];
			sspc_pkg::CFG_MAX_BOOST: cfg_max_boost = data[SW-1:0];
			default: ;
		endcase
	endtask

	task automatic push_cmd(logic [OW-1:0] op, logic l, logic r);
		motor_cmd_t c;
		c.opcode       = op;
		c.left_switch  = l;
		c.right_switch = r;
		pending_cmds.push_back(c);
	endtask

	// all commands sent and every result back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || in_ch.valid || expected_status.size() != 0);
	endtask

	// Random commands. Ticks come in runs with a held switch pair (mostly one
	// switch on, so the motor steps); the rest are speed changes, mode ops, spares.
	// Switch bits on non-tick commands are random, the block must ignore them.
	task automatic queue_random(int n, int w_tick, int w_inc, int w_dec);
		int unsigned r;
		@(negedge clk);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < w_tick) begin
				if ($urandom_range(0, 99) < 6) begin
					case ($urandom_range(0, 9))
						0: {sw_left, sw_right} = 2'b00;
						1: {sw_left, sw_right} = 2'b11;
						2, 3, 4, 5: {sw_left, sw_right} = 2'b10;
						default: {sw_left, sw_right} = 2'b01;
					endcase
				end
				push_cmd(sspc_pkg::OP_TICK, sw_left, sw_right);
			end else if (r < w_tick + w_inc) begin
				push_cmd(sspc_pkg::OP_INC, rand_bit(), rand_bit());
			end else if (r < w_tick + w_inc + w_dec) begin
				push_cmd(sspc_pkg::OP_DEC, rand_bit(), rand_bit());
			end else begin
				case ($urandom_range(0, 5))
					0, 5: push_cmd(sspc_pkg::OP_TOGGLE, rand_bit(), rand_bit());
					1: push_cmd(sspc_pkg::OP_BOOST_ON, rand_bit(), rand_bit());
					2: push_cmd(sspc_pkg::OP_BOOST_OFF, rand_bit(), rand_bit());
					3: push_cmd(OP_SPARE6, rand_bit(), rand_bit());
					default: push_cmd(OP_SPARE7, rand_bit(), rand_bit());
				endcase
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.opcode       = sspc_pkg::OP_TICK;
		in_ch.left_switch  = 1'b0;
		in_ch.right_switch = 1'b0;
		out_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = sspc_pkg::CFG_BASE;
		cfg_ch.wdata       = '0;
		reset_motor_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset state, every opcode, stop/start, one-decade boundary
		push_cmd(OP_SPARE6, 1'b0, 1'b0);    // report reset state
		push_cmd(OP_SPARE7, 1'b1, 1'b1);
		push_cmd(sspc_pkg::OP_TICK, 1'b0, 1'b0);      // stopped
		push_cmd(sspc_pkg::OP_TICK, 1'b1, 1'b1);      // both on also stops
		push_cmd(sspc_pkg::OP_TICK, 1'b1, 1'b0);      // start left, step stays low
		push_cmd(sspc_pkg::OP_TICK, 1'b0, 1'b1);      // direction flips right
		push_cmd(sspc_pkg::OP_INC, 1'b1, 1'b1);
		push_cmd(sspc_pkg::OP_DEC, 1'b0, 1'b1);
		push_cmd(sspc_pkg::OP_DEC, 1'b1, 1'b0);       // 9: below one decade, divisor 1
		push_cmd(sspc_pkg::OP_TICK, 1'b0, 1'b1);
		push_cmd(sspc_pkg::OP_TOGGLE, 1'b0, 1'b0);    // now acting on boost
		push_cmd(sspc_pkg::OP_INC, 1'b0, 1'b0);
		push_cmd(sspc_pkg::OP_DEC, 1'b1, 1'b1);
		push_cmd(sspc_pkg::OP_BOOST_ON, 1'b0, 1'b1);
		push_cmd(sspc_pkg::OP_TICK, 1'b1, 1'b0);
		push_cmd(sspc_pkg::OP_BOOST_OFF, 1'b1, 1'b0);
		push_cmd(sspc_pkg::OP_TOGGLE, 1'b1, 1'b1);
		push_cmd(sspc_pkg::OP_INC, 1'b1, 1'b0);       // switches ignored off-tick
		push_cmd(sspc_pkg::OP_TICK, 1'b0, 1'b0);
		wait_idle();

		// wide limits, short base; dropped index, oversized data masked
		cfg_write(CFG_NONE_HI, 16'hFFFF);
		cfg_write(sspc_pkg::CFG_BASE, 16'd120);
		cfg_write(sspc_pkg::CFG_MIN_SPEED, 16'hFC00);
		cfg_write(sspc_pkg::CFG_MAX_NORM, 16'hFFFF);
		cfg_write(sspc_pkg::CFG_MAX_BOOST, 16'd1023);
		queue_random(150, 40, 10, 40);       // drives speeds down toward zero
		wait_idle();

		// base of 1: recomputed half periods collapse to 0/1, step then toggles every running tick
		cfg_write(sspc_pkg::CFG_BASE, 16'd1);
		queue_random(120, 60, 15, 15);
		wait_idle();

		// limits pinned: increase and decrease both stuck
		cfg_write(sspc_pkg::CFG_BASE, 16'hFFFF);
		cfg_write(sspc_pkg::CFG_MIN_SPEED, 16'd1023);
		cfg_write(sspc_pkg::CFG_MAX_NORM, 16'd0);
		cfg_write(sspc_pkg::CFG_MAX_BOOST, 16'd0);
		cfg_write(CFG_NONE_LO, 16'd5);
		queue_random(80, 30, 30, 30);
		wait_idle();

		// random settings, mostly short bases so the step output moves
		repeat (3) begin
			cfg_write(sspc_pkg::CFG_BASE, DW'(($urandom_range(0, 9) == 0) ?
				$urandom_range(1, 65535) : $urandom_range(1, 800)));
			cfg_write(sspc_pkg::CFG_MIN_SPEED, DW'($urandom_range(0, 20)));
			cfg_write(sspc_pkg::CFG_MAX_NORM, DW'($urandom_range(30, 1023)));
			cfg_write(sspc_pkg::CFG_MAX_BOOST, DW'($urandom_range(30, 1023)));
			queue_random(100, 60, 15, 15);
			wait_idle();
		end

		// long stretch with no bubbles on either side
		cfg_write(sspc_pkg::CFG_BASE, 16'd400);
		cfg_write(sspc_pkg::CFG_MIN_SPEED, DW'(sspc_pkg::RST_MIN_SPEED));
		cfg_write(sspc_pkg::CFG_MAX_NORM, DW'(sspc_pkg::RST_MAX_NORM));
		cfg_write(sspc_pkg::CFG_MAX_BOOST, DW'(sspc_pkg::RST_MAX_BOOST));
		sender_steady   = 1'b1;
		receiver_steady = 1'b1;
		queue_random(150, 60, 20, 10);
		wait_idle();

		// back-pressure: receiver holds off, sender keeps offering
		receiver_steady = 1'b0;
		hold_req = 1'b1;
		queue_random(100, 60, 15, 15);
		wait_idle();
		sender_steady = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("stepper_speed_pulse_controller: match");
		end else begin
			$display("stepper_speed_pulse_controller: mismatch");
		end
		$finish;
	end

endmodule
